// ===== rtl/rcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants of the rc pwm speed decoder: command codes,
// field widths, register indexes and reset values, divider status.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

    // command codes carried in the input tuser
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPEED   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

    // field widths
    localparam int TIME_W   = 16;
    localparam int DUTY_W   = 26;
    localparam int FREQ_W   = 27;
    localparam int SPEED_W  = 9;
    localparam int VALUE_W  = 8;
    localparam int HOLD_W   = 5;
    localparam int WIN_W    = 10;
    localparam int DB_W     = 7;
    localparam int CLK_W    = 27;

    // stream packing widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 1;

    // serial divider: one quotient bit per cycle
    localparam int QUO_W     = 27;
    localparam int DIV_STEPS = 27;
    localparam int STEP_W    = 5;

    // duty scale, per mille
    localparam logic [DUTY_W-1:0] DUTY_SCALE = 26'd1000;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DUTY  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_UPDATES = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK  = 4'd7;

    // register reset values
    localparam logic [WIN_W-1:0]  RST_DUTY_MIN     = 10'd50;
    localparam logic [WIN_W-1:0]  RST_DUTY_MAX     = 10'd150;
    localparam logic [WIN_W-1:0]  RST_CENTER_DUTY  = 10'd97;
    localparam logic [DB_W-1:0]   RST_DEADBAND     = 7'd4;
    localparam logic [HOLD_W-1:0] RST_HOLD_UPDATES = 5'd5;
    localparam logic [WIN_W-1:0]  RST_STOP_LOW     = 10'd10;
    localparam logic [WIN_W-1:0]  RST_STOP_HIGH    = 10'd70;
    localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK  = 27'd1000000;

    // divider status toward the top level
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo_duty;
        logic [QUO_W-1:0] quo_freq;
    } div_status_t;

endpackage

// ===== rtl/rcpwm_div.sv =====
// ----------------------------------------------------------------------------
// rcpwm_div
// Two-lane restoring divider sharing one divisor; each lane retires one
// quotient bit per cycle until all DIV_STEPS bits are shifted in, then raises done.
// ----------------------------------------------------------------------------
module rcpwm_div
    import rcpwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUO_W-1:0]  dividend_duty,
    input  logic [QUO_W-1:0]  dividend_freq,
    input  logic [TIME_W-1:0] divisor,
    output div_status_t       status
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]   divisor_reg, divisor_next;
    logic [TIME_W-1:0]   rem_duty_reg, rem_duty_next;
    logic [TIME_W-1:0]   rem_freq_reg, rem_freq_next;
    logic [QUO_W-1:0]    quo_duty_reg, quo_duty_next;
    logic [QUO_W-1:0]    quo_freq_reg, quo_freq_next;

    logic [TIME_W:0]     shift_duty, shift_freq;
    logic [TIME_W:0]     diff_duty, diff_freq;
    logic                ge_duty, ge_freq;

    // one restoring step per lane
    always_comb
    begin
        shift_duty = {rem_duty_reg, quo_duty_reg[QUO_W-1]};
        shift_freq = {rem_freq_reg, quo_freq_reg[QUO_W-1]};
        ge_duty    = shift_duty >= {1'b0, divisor_reg};
        ge_freq    = shift_freq >= {1'b0, divisor_reg};
        diff_duty  = shift_duty - {1'b0, divisor_reg};
        diff_freq  = shift_freq - {1'b0, divisor_reg};
    end

    // sequencing of the run
    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        divisor_next  = divisor_reg;
        rem_duty_next = rem_duty_reg;
        rem_freq_next = rem_freq_reg;
        quo_duty_next = quo_duty_reg;
        quo_freq_next = quo_freq_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            count_next    = STEP_W'(DIV_STEPS - 1);
            divisor_next  = divisor;
            rem_duty_next = '0;
            rem_freq_next = '0;
            quo_duty_next = dividend_duty;
            quo_freq_next = dividend_freq;
        end
        else if (busy_reg)
        begin
            rem_duty_next = ge_duty ? diff_duty[TIME_W-1:0] : shift_duty[TIME_W-1:0];
            rem_freq_next = ge_freq ? diff_freq[TIME_W-1:0] : shift_freq[TIME_W-1:0];
            quo_duty_next = {quo_duty_reg[QUO_W-2:0], ge_duty};
            quo_freq_next = {quo_freq_reg[QUO_W-2:0], ge_freq};
            count_next    = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        divisor_reg  <= divisor_next;
        rem_duty_reg <= rem_duty_next;
        rem_freq_reg <= rem_freq_next;
        quo_duty_reg <= quo_duty_next;
        quo_freq_reg <= quo_freq_next;
    end

    assign status.done     = done_reg;
    assign status.quo_duty = quo_duty_reg;
    assign status.quo_freq = quo_freq_reg;

endmodule

// ===== rtl/rc_pwm_speed_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rc_pwm_speed_decoder_unit
// Remote-control PWM decoder: capture, speed update and stop check commands.
// ----------------------------------------------------------------------------
// One request in gives one result out. A capture with a nonzero period runs
// the two-lane serial divider (duty = high*1000/period, frequency =
// clock/period), one quotient bit per cycle: the request is taken and the
// divider loaded, the quotient bits are shifted in, the quotients are stored,
// and the result is posted to the output register once that register is free.
// A capture with a zero period, a speed update and a stop check skip the
// division and go straight to posting the result. One request
// is handled at a time; the result sits in an output register, so the next
// request is taken while the previous result waits.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
module rc_pwm_speed_decoder_unit
    import rcpwm_pkg::*;
#(
    parameter int HOLD_CAP = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // high_time[15:0], period[31:16]
    input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // speed[8:0], duty_per_mille[34:9],
                                             // frequency_hz[61:35], zero[63:62]
    output logic [M_USER_W-1:0]   m_tuser,   // speed_valid[0]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(HOLD_CAP);

    logic [1:0]          state_reg, state_next;

    // configuration registers
    logic [WIN_W-1:0]    duty_min_reg, duty_max_reg, center_duty_reg;
    logic [WIN_W-1:0]    stop_low_reg, stop_high_reg;
    logic [DB_W-1:0]     deadband_reg;
    logic [HOLD_W-1:0]   hold_updates_reg;
    logic [CLK_W-1:0]    timer_clock_reg;

    // decoder state
    logic [DUTY_W-1:0]   duty_store_reg, duty_store_next;
    logic [FREQ_W-1:0]   freq_store_reg, freq_store_next;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;

    // pending result
    logic                res_valid_reg, res_valid_next;
    logic [SPEED_W-1:0]  res_speed_reg, res_speed_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                req_fire, out_load;
    logic [TIME_W-1:0]   in_high, in_period;
    logic [QUO_W-1:0]    dividend_duty;
    logic                div_start;
    div_status_t         div_status;

    // speed path
    logic                in_window, dead, emit, stop_hit;
    logic [8:0]          diff9;
    logic signed [8:0]   value9, db9, value_z;
    logic [HOLD_W-1:0]   hold_inc, hold_after;

    assign in_high   = s_tdata[TIME_W-1:0];
    assign in_period = s_tdata[2*TIME_W-1:TIME_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign req_fire  = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // divider launch
    assign dividend_duty = {1'b0, DUTY_W'(in_high) * DUTY_SCALE};
    assign div_start     = req_fire && (s_tuser == CMD_CAPTURE) && (in_period != '0);

    rcpwm_div u_div
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .dividend_duty (dividend_duty),
        .dividend_freq (timer_clock_reg),
        .divisor       (in_period),
        .status        (div_status)
    );

    // speed value from stored duty: window, halving, deadband, hold filter; stop window check
    always_comb
    begin
        in_window = (duty_store_reg > DUTY_W'(duty_min_reg))
                 && (duty_store_reg < DUTY_W'(duty_max_reg));
        diff9     = duty_store_reg[8:0] - center_duty_reg[8:0];
        value9    = in_window ? signed'({diff9[8], diff9[8:1]}) : 9'sd0;
        db9       = signed'({2'b00, deadband_reg});
        dead      = (value9 < db9) && (value9 > -db9);
        value_z   = dead ? 9'sd0 : value9;
        hold_inc  = (hold_count_reg >= HOLD_MAX) ? HOLD_MAX : hold_count_reg + 1'b1;
        hold_after = (value_z == 9'sd0) ? '0 : hold_inc;
        emit      = (value_z == 9'sd0) || (hold_after > hold_updates_reg);
        stop_hit  = (duty_store_reg > DUTY_W'(stop_low_reg))
                 && (duty_store_reg < DUTY_W'(stop_high_reg));
    end

    // command handling
    always_comb
    begin
        state_next      = state_reg;
        duty_store_next = duty_store_reg;
        freq_store_next = freq_store_reg;
        hold_count_next = hold_count_reg;
        res_valid_next  = res_valid_reg;
        res_speed_next  = res_speed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    res_valid_next = 1'b0;
                    res_speed_next = '0;
                    state_next     = ST_OUT;
                    case (s_tuser)
                        CMD_CAPTURE:
                        begin
                            if (in_period == '0)
                            begin
                                duty_store_next = '0;
                                freq_store_next = '0;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        CMD_SPEED:
                        begin
                            hold_count_next = emit ? '0 : hold_after;
                            if (emit)
                            begin
                                res_valid_next = 1'b1;
                                res_speed_next = {value_z[7:0], 1'b0};
                            end
                        end
                        CMD_STOP:
                        begin
                            res_valid_next = stop_hit;
                        end
                        default:
                        begin
                            res_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    duty_store_next = div_status.quo_duty[DUTY_W-1:0];
                    freq_store_next = div_status.quo_freq;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, freq_store_reg, duty_store_reg, res_speed_reg};
            m_tuser_next  = res_valid_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            duty_store_reg <= '0;
            freq_store_reg <= '0;
            hold_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            duty_store_reg <= duty_store_next;
            freq_store_reg <= freq_store_next;
            hold_count_reg <= hold_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_valid_reg <= res_valid_next;
        res_speed_reg <= res_speed_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg     <= RST_DUTY_MIN;
            duty_max_reg     <= RST_DUTY_MAX;
            center_duty_reg  <= RST_CENTER_DUTY;
            deadband_reg     <= RST_DEADBAND;
            hold_updates_reg <= RST_HOLD_UPDATES;
            stop_low_reg     <= RST_STOP_LOW;
            stop_high_reg    <= RST_STOP_HIGH;
            timer_clock_reg  <= RST_TIMER_CLOCK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DUTY_MIN:     duty_min_reg     <= cfg_data[WIN_W-1:0];
                REG_DUTY_MAX:     duty_max_reg     <= cfg_data[WIN_W-1:0];
                REG_CENTER_DUTY:  center_duty_reg  <= cfg_data[WIN_W-1:0];
                REG_DEADBAND:     deadband_reg     <= cfg_data[DB_W-1:0];
                REG_HOLD_UPDATES: hold_updates_reg <= cfg_data[HOLD_W-1:0];
                REG_STOP_LOW:     stop_low_reg     <= cfg_data[WIN_W-1:0];
                REG_STOP_HIGH:    stop_high_reg    <= cfg_data[WIN_W-1:0];
                REG_TIMER_CLOCK:  timer_clock_reg  <= cfg_data[CLK_W-1:0];
                default:
                begin
                    timer_clock_reg <= timer_clock_reg;
                end
            endcase
        end
    end

    // hold counter never passes its cap
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg <= HOLD_MAX)
        else $error("hold counter above cap");

    // a result without speed_valid carries zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[SPEED_W-1:0] == '0))
        else $error("nonzero speed without speed_valid");

    // a capture with zero period clears both stores at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (s_tuser == CMD_CAPTURE) && (in_period == '0))
            |=> (duty_store_reg == '0) && (freq_store_reg == '0)
                && (state_reg == ST_OUT))
        else $error("zero period capture did not clear stores");

endmodule

// ===== bench/tb_rc_pwm_speed_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rc_pwm_speed_decoder_unit
// Self-checking bench for the rc pwm speed decoder. A short table of directed
// requests runs first at the reset settings. It is followed by random request
// streams over several register settings, including the extreme ones, with
// idle and stall patterns on both streams and one long result back-pressure.
// Each result is compared with a cycle-free model or the row's typed values.
// ----------------------------------------------------------------------------
module tb_rc_pwm_speed_decoder_unit;
    import rcpwm_pkg::*;

    localparam int HOLD_CAP        = 20;
    localparam int NUM_REGS        = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int IDLE_PCT        = 81;
    localparam int LIGHT_IDLE_PCT  = 6;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] period;
    } pwm_request_t;

    typedef struct packed {
        logic               speed_valid;
        logic [SPEED_W-1:0] speed;
        logic [DUTY_W-1:0]  duty;
        logic [FREQ_W-1:0]  freq;
    } pwm_result_t;

    typedef struct {
        pwm_request_t req;
        bit           typed;
        pwm_result_t  want;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // high_time[15:0], period[31:16]
    logic [CMD_W-1:0]      s_tuser;   // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // speed[8:0], duty_per_mille[34:9],
                                      // frequency_hz[61:35], zero[63:62]
    logic [M_USER_W-1:0]   m_tuser;   // speed_valid[0]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // decoder model: registers and state
    logic [WIN_W-1:0]  duty_min_q;
    logic [WIN_W-1:0]  duty_max_q;
    logic [WIN_W-1:0]  center_q;
    logic [DB_W-1:0]   deadband_q;
    logic [HOLD_W-1:0] hold_updates_q;
    logic [WIN_W-1:0]  stop_low_q;
    logic [WIN_W-1:0]  stop_high_q;
    logic [CLK_W-1:0]  timer_clock_q;
    logic [DUTY_W-1:0] duty_q;
    logic [FREQ_W-1:0] freq_q;
    logic [HOLD_W-1:0] hold_q;

    pwm_result_t   expected_results[$];
    directed_row_t directed_rows[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_requested;
    int hold_off_served;
    int hold_off_left;
    int idle_cycles;
    int n_errors;
    int n_requests;
    int n_results;
    int n_speed_commands;
    int n_stop_hits;
    int n_cfg_writes;

    rc_pwm_speed_decoder_unit #(
        .HOLD_CAP (HOLD_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // decoder model: advance state for one request, return its result
    function automatic pwm_result_t decode_request(input pwm_request_t req);
        pwm_result_t        res;
        logic [31:0]        diff;
        logic [VALUE_W-1:0] half;
        int                 value;
        res   = '0;
        value = 0;
        case (req.cmd)
            CMD_CAPTURE:
            begin
                if (req.period != '0)
                begin
                    duty_q = DUTY_W'((32'(req.high_time) * 32'(DUTY_SCALE)) / 32'(req.period));
                    freq_q = FREQ_W'(32'(timer_clock_q) / 32'(req.period));
                end
                else
                begin
                    duty_q = '0;
                    freq_q = '0;
                end
            end
            CMD_SPEED:
            begin
                if (duty_q > DUTY_W'(duty_min_q) && duty_q < DUTY_W'(duty_max_q))
                begin
                    diff  = 32'(duty_q) - 32'(center_q);
                    half  = diff[VALUE_W:1];
                    value = int'($signed(half));
                end
                if (value < int'(deadband_q) && value > -int'(deadband_q))
                    value = 0;
                if (value == 0)
                    hold_q = '0;
                else if (hold_q < HOLD_W'(HOLD_CAP))
                    hold_q = hold_q + 1'b1;
                if (hold_q > hold_updates_q || value == 0)
                begin
                    res.speed_valid = 1'b1;
                    res.speed       = SPEED_W'(2 * value);
                    hold_q          = '0;
                end
            end
            CMD_STOP:
            begin
                if (DUTY_W'(stop_low_q) < duty_q && duty_q < DUTY_W'(stop_high_q))
                    res.speed_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.duty = duty_q;
        res.freq = freq_q;
        return res;
    endfunction

    // queue one directed row
    task automatic add_row(input logic [CMD_W-1:0] cmd, input int unsigned high,
                           input int unsigned per, input bit typed, input bit valid,
                           input int speed, input int unsigned duty,
                           input int unsigned freq);
        directed_row_t row;
        row.req.cmd          = cmd;
        row.req.high_time    = TIME_W'(high);
        row.req.period       = TIME_W'(per);
        row.typed            = typed;
        row.want.speed_valid = valid;
        row.want.speed       = SPEED_W'(speed);
        row.want.duty        = DUTY_W'(duty);
        row.want.freq        = FREQ_W'(freq);
        directed_rows.push_back(row);
    endtask

    // offer one request after a random gap, record its expected result on accept
    task automatic send_request(input pwm_request_t req, input bit typed,
                                input pwm_result_t want);
        pwm_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= {req.period, req.high_time};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = decode_request(req);
        expected_results.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    // one register write, mirrored into the model when taken
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_DUTY_MIN:     duty_min_q     = value[WIN_W-1:0];
            REG_DUTY_MAX:     duty_max_q     = value[WIN_W-1:0];
            REG_CENTER_DUTY:  center_q       = value[WIN_W-1:0];
            REG_DEADBAND:     deadband_q     = value[DB_W-1:0];
            REG_HOLD_UPDATES: hold_updates_q = value[HOLD_W-1:0];
            REG_STOP_LOW:     stop_low_q     = value[WIN_W-1:0];
            REG_STOP_HIGH:    stop_high_q    = value[WIN_W-1:0];
            REG_TIMER_CLOCK:  timer_clock_q  = value[CLK_W-1:0];
            default:
            begin
            end
        endcase
        n_cfg_writes++;
    endtask

    // stop offering, wait for every result, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // result receiver with random stalls and the long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_served != hold_off_requested)
            begin
                hold_off_served++;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // result check and handshake activity count
    always @(posedge clk)
    begin : result_check
        pwm_result_t got;
        pwm_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.speed_valid = m_tuser[0];
                got.speed       = m_tdata[SPEED_W-1:0];
                got.duty        = m_tdata[SPEED_W +: DUTY_W];
                got.freq        = m_tdata[SPEED_W+DUTY_W +: FREQ_W];
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with no request pending, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("speed_valid", 32'(want.speed_valid), 32'(got.speed_valid));
                    compare_field("speed", 32'(want.speed), 32'(got.speed));
                    compare_field("duty_per_mille", 32'(want.duty), 32'(got.duty));
                    compare_field("frequency_hz", 32'(want.freq), 32'(got.freq));
                    compare_field("tdata padding", 32'd0,
                                  32'(m_tdata[M_DATA_W-1:SPEED_W+DUTY_W+FREQ_W]));
                end
                n_results++;
                if (got.speed_valid && got.speed != '0)
                    n_speed_commands++;
                if (got.speed_valid && got.speed == '0)
                    n_stop_hits++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on handshake activity
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        pwm_request_t    req;
        pwm_result_t     none;
        int unsigned     settings[NUM_REGS];
        int unsigned     target;
        int unsigned     scaled;
        int              roll;
        int              shape;
        int              w;

        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_requested = 0;
        hold_off_served    = 0;
        hold_off_left      = 0;
        idle_cycles        = 0;
        n_errors           = 0;
        n_requests         = 0;
        n_results          = 0;
        n_speed_commands   = 0;
        n_stop_hits        = 0;
        n_cfg_writes       = 0;
        none               = '0;

        // model at reset
        duty_min_q     = RST_DUTY_MIN;
        duty_max_q     = RST_DUTY_MAX;
        center_q       = RST_CENTER_DUTY;
        deadband_q     = RST_DEADBAND;
        hold_updates_q = RST_HOLD_UPDATES;
        stop_low_q     = RST_STOP_LOW;
        stop_high_q    = RST_STOP_HIGH;
        timer_clock_q  = RST_TIMER_CLOCK;
        duty_q         = '0;
        freq_q         = '0;
        hold_q         = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        add_row(CMD_SPEED, 0, 0, 1, 1, 0, 0, 0);
        add_row(CMD_STOP, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_CAPTURE, 65535, 0, 1, 0, 0, 0, 0);
        add_row(CMD_UNUSED, 65535, 65535, 1, 0, 0, 0, 0);
        add_row(CMD_CAPTURE, 65535, 1, 1, 0, 0, 65535000, 1000000);
        add_row(CMD_CAPTURE, 65535, 65535, 1, 0, 0, 1000, 15);
        add_row(CMD_CAPTURE, 0, 65535, 1, 0, 0, 0, 15);
        add_row(CMD_STOP, 0, 0, 1, 0, 0, 0, 15);
        // duty inside the stop window, below the speed window
        add_row(CMD_CAPTURE, 3, 100, 0, 0, 0, 0, 0);
        add_row(CMD_STOP, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_SPEED, 0, 0, 0, 0, 0, 0, 0);
        // duty at the exclusive upper bound
        add_row(CMD_CAPTURE, 150, 1000, 0, 0, 0, 0, 0);
        add_row(CMD_SPEED, 0, 0, 0, 0, 0, 0, 0);
        // in window: hold filter releases after the threshold is passed
        add_row(CMD_CAPTURE, 149, 1000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            add_row(CMD_SPEED, 0, 0, 0, 0, 0, 0, 0);
        // negative value, then one inside the deadband clears the hold count
        add_row(CMD_CAPTURE, 51, 1000, 0, 0, 0, 0, 0);
        add_row(CMD_SPEED, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_CAPTURE, 96, 1000, 0, 0, 0, 0, 0);
        add_row(CMD_SPEED, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_UNUSED, 43690, 21845, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_idle();

        // random phases over several settings and idle patterns
        for (int k = 0; k < PHASES; k++)
        begin
            case (k)
                0:
                begin
                    settings = '{RST_DUTY_MIN, RST_DUTY_MAX, RST_CENTER_DUTY, RST_DEADBAND,
                                 RST_HOLD_UPDATES, RST_STOP_LOW, RST_STOP_HIGH,
                                 RST_TIMER_CLOCK};
                end
                1:
                begin
                    // widest windows, no deadband, no hold, fastest clock
                    settings = '{0, 1023, 0, 0, 0, 0, 1023, 32'h7FF_FFFF};
                end
                2:
                begin
                    // empty stop window, deadband and hold at maximum, zero clock
                    settings = '{0, 1023, 1023, 127, 31, 1023, 0, 0};
                end
                default:
                begin
                    settings[REG_DUTY_MIN]     = $urandom_range(0, 120);
                    settings[REG_DUTY_MAX]     = $urandom_range(settings[REG_DUTY_MIN] + 20,
                                                                1023);
                    settings[REG_CENTER_DUTY]  = $urandom_range(settings[REG_DUTY_MIN],
                                                                settings[REG_DUTY_MAX]);
                    settings[REG_DEADBAND]     = $urandom_range(0, 12);
                    settings[REG_HOLD_UPDATES] = (k == 3) ? HOLD_CAP : $urandom_range(0, 7);
                    settings[REG_STOP_LOW]     = $urandom_range(0, 200);
                    settings[REG_STOP_HIGH]    = $urandom_range(settings[REG_STOP_LOW], 1023);
                    settings[REG_TIMER_CLOCK]  = $urandom_range(1, 100000000);
                end
            endcase

            // every register, with junk above its width, plus one unused index
            for (int i = 0; i < NUM_REGS; i++)
            begin
                case (i)
                    REG_DEADBAND:     w = DB_W;
                    REG_HOLD_UPDATES: w = HOLD_W;
                    REG_TIMER_CLOCK:  w = CLK_W;
                    default:          w = WIN_W;
                endcase
                write_register(CFG_IDX_W'(i),
                               CFG_DATA_W'(settings[i] | ({$urandom} << w)));
            end
            write_register(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                           CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            case (k % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = IDLE_PCT;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = IDLE_PCT;
                end
                default:
                begin
                    sender_idle_pct    = LIGHT_IDLE_PCT;
                    receiver_stall_pct = LIGHT_IDLE_PCT;
                end
            endcase
            // long result back-pressure while requests keep coming
            if (k == 0)
                hold_off_requested++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll          = $urandom_range(0, 99);
                req.high_time = TIME_W'($urandom);
                req.period    = TIME_W'($urandom);
                if (roll < 40)
                begin
                    req.cmd = CMD_CAPTURE;
                    shape   = $urandom_range(0, 9);
                    if (shape == 0)
                        req.period = '0;
                    else if (shape >= 3)
                    begin
                        // aim the duty at the speed window half of the time
                        req.period = TIME_W'((shape < 6) ? $urandom_range(1, 2000)
                                                         : $urandom_range(1, 65535));
                        if ($urandom_range(0, 1) != 0)
                            target = $urandom_range(duty_min_q, duty_max_q);
                        else
                            target = $urandom_range(0, 1100);
                        scaled = (target * req.period + $urandom_range(0, 999)) / 1000;
                        req.high_time = TIME_W'((scaled > 65535) ? 65535 : scaled);
                    end
                end
                else if (roll < 80)
                    req.cmd = CMD_SPEED;
                else if (roll < 95)
                    req.cmd = CMD_STOP;
                else
                    req.cmd = CMD_UNUSED;
                send_request(req, 1'b0, none);
            end
            wait_idle();
        end

        $display("covered %0d requests and %0d results over %0d register settings",
                 n_requests, n_results, PHASES + 1);
        $display("speed commands %0d, zero-speed emits %0d, register writes %0d, errors %0d",
                 n_speed_commands, n_stop_hits, n_cfg_writes, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
